FILE: rtl/bbat_pkg.sv
// Shared types and constants for the banked bump allocator with handle table.
package bbat_pkg;

	localparam int BANK_BYTES  = 8192;
	localparam int MAX_HANDLES = 256;
	localparam int TABLE_BANK  = 1;

	localparam int BANK_W   = 8;
	localparam int HANDLE_W = 8;
	localparam int COUNT_W  = 15;
	localparam int SIZE_W   = 14;
	localparam int INDEX_W  = 16;
	localparam int ADDR_W   = 16;
	localparam int STATUS_W = 2;
	localparam int SHIFT_W  = 4;
	localparam int OFF_W    = $clog2(BANK_BYTES) + 1;
	localparam int TOTAL_W  = COUNT_W + SIZE_W;
	localparam int NH_W     = $clog2(MAX_HANDLES + 1);
	localparam int TAB_AW   = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;

	localparam logic [BANK_W-1:0]   BANK_LAST  = '1;
	localparam logic [SHIFT_W-1:0]  SELF_SHIFT = 4'd3;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BOUNDS    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic [BANK_W-1:0]  bank;
		logic [OFF_W-1:0]   offset;
		logic [COUNT_W-1:0] count;
		logic [SHIFT_W-1:0] shift;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	localparam desc_t SELF_DESC = '{
		bank:   BANK_W'(TABLE_BANK),
		offset: '0,
		count:  COUNT_W'(BANK_BYTES >> 3),
		shift:  SELF_SHIFT
	};

	// controller to datapath
	typedef struct packed {
		logic capture;  // request beat taken, latch fields and start table read
		logic finish;   // resolve request, commit state, load result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_valid;
	} stat_t;

endpackage

FILE: rtl/bbat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/bbat_ctrl.sv
// Request sequencer: accepts a beat, then resolves it once the result register is free.
module bbat_ctrl
	import bbat_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_axis_tvalid,
	output logic  s_axis_tready,
	input  logic  m_axis_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       out_free;

	assign out_free      = !stat.out_valid || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign cmd.capture   = (state_q == S_IDLE) && s_axis_tvalid;
	assign cmd.finish    = (state_q == S_EXEC) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC))
		else $error("capture not followed by execute");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.finish))
		else $error("capture and finish in one cycle");
	a_finish_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && $past(state_q == S_IDLE) |-> $past(cmd.capture))
		else $error("finish without a captured request");
`endif

endmodule

FILE: rtl/bbat_dp.sv
// Datapath: allocator state, descriptor table, translate arithmetic, result register.
module bbat_dp
	import bbat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  cfg_valid,
	input  logic [ADDR_W-1:0]     cfg_data,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [STATUS_W-1:0]   m_axis_tuser
);

	function automatic logic [SHIFT_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
		logic [SHIFT_W-1:0] r;
		r = '0;
		for (int s = 0; s < SIZE_W; s++) begin
			if (((SIZE_W+1)'(1) << s) < (SIZE_W+1)'(v)) r = SHIFT_W'(s + 1);
		end
		return r;
	endfunction

	// input fields
	logic [COUNT_W-1:0]  in_count;
	logic [SIZE_W-1:0]   in_size;
	logic [HANDLE_W-1:0] in_handle;
	logic [INDEX_W-1:0]  in_index;

	assign in_count  = s_axis_tdata[COUNT_W-1:0];
	assign in_size   = s_axis_tdata[COUNT_W+SIZE_W-1:COUNT_W];
	assign in_handle = s_axis_tdata[COUNT_W+SIZE_W+HANDLE_W-1:COUNT_W+SIZE_W];
	assign in_index  = s_axis_tdata[COUNT_W+SIZE_W+HANDLE_W+INDEX_W-1:COUNT_W+SIZE_W+HANDLE_W];

	// captured request
	logic                req_s1;
	logic [COUNT_W-1:0]  count_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic [TOTAL_W-1:0]  total_s1;
	logic [SHIFT_W-1:0]  shift_s1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1    <= s_axis_tuser;
			count_s1  <= in_count;
			handle_s1 <= in_handle;
			index_s1  <= in_index;
			total_s1  <= TOTAL_W'(in_count) * TOTAL_W'(in_size);
			shift_s1  <= ceil_log2(in_size);
		end
	end

	// allocator state and window base
	logic [NH_W-1:0]   next_handle_q;
	logic [BANK_W-1:0] bank_q;
	logic [OFF_W-1:0]  offset_q;
	logic [ADDR_W-1:0] window_base_q;

	// descriptor table
	logic              tab_we;
	desc_t             tab_wdata;
	logic [DESC_W-1:0] tab_rdata;

	bbat_ram #(
		.WIDTH(DESC_W),
		.DEPTH(MAX_HANDLES)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (next_handle_q[TAB_AW-1:0]),
		.wdata (tab_wdata),
		.re    (cmd.capture),
		.raddr (in_handle[TAB_AW-1:0]),
		.rdata (tab_rdata)
	);

	// allocate path
	logic              too_large;
	logic              no_handle;
	logic              need_bank;
	logic              no_bank;
	logic              alloc_ok;
	logic [BANK_W-1:0] alloc_bank;
	logic [OFF_W-1:0]  alloc_off;

	assign too_large  = total_s1 > TOTAL_W'(BANK_BYTES);
	assign no_handle  = next_handle_q >= NH_W'(MAX_HANDLES);
	assign need_bank  = (TOTAL_W'(BANK_BYTES) - TOTAL_W'(offset_q)) < total_s1;
	assign no_bank    = need_bank && (bank_q >= BANK_LAST);
	assign alloc_ok   = !too_large && !no_handle && !no_bank;
	assign alloc_bank = need_bank ? bank_q + BANK_W'(1) : bank_q;
	assign alloc_off  = need_bank ? '0 : offset_q;

	assign tab_we           = cmd.finish && (req_s1 == REQ_ALLOC) && alloc_ok;
	assign tab_wdata.bank   = alloc_bank;
	assign tab_wdata.offset = alloc_off;
	assign tab_wdata.count  = count_s1;
	assign tab_wdata.shift  = shift_s1;

	// translate path; entry 0 is the fixed self descriptor
	desc_t             desc;
	logic              xl_bad;
	logic [ADDR_W-1:0] xl_addr;

	assign desc    = (handle_s1 == '0) ? SELF_DESC : desc_t'(tab_rdata);
	assign xl_bad  = ((NH_W+1)'(handle_s1) >= (NH_W+1)'(MAX_HANDLES)) || index_s1[INDEX_W-1]
		|| (index_s1 >= INDEX_W'(desc.count));
	assign xl_addr = window_base_q + ADDR_W'(desc.offset) + (ADDR_W'(index_s1) << desc.shift);

	// result selection
	logic [HANDLE_W-1:0] res_handle;
	logic [BANK_W-1:0]   res_bank;
	logic [ADDR_W-1:0]   res_addr;
	logic [STATUS_W-1:0] res_status;

	always_comb begin
		res_handle = '0;
		res_bank   = '0;
		res_addr   = '0;
		res_status = STAT_OK;
		if (req_s1 == REQ_ALLOC) begin
			if (too_large) begin
				res_status = STAT_TOO_LARGE;
			end else if (!alloc_ok) begin
				res_status = STAT_EXHAUSTED;
			end else begin
				res_handle = next_handle_q[HANDLE_W-1:0];
			end
		end else begin
			if (xl_bad) begin
				res_status = STAT_BOUNDS;
			end else begin
				res_bank = desc.bank;
				res_addr = xl_addr;
			end
		end
	end

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_handle_q <= NH_W'(1);
			bank_q        <= BANK_W'(TABLE_BANK + 1);
			offset_q      <= '0;
			window_base_q <= ADDR_W'(40960);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) window_base_q <= cfg_data;
			if (tab_we) begin
				next_handle_q <= next_handle_q + NH_W'(1);
				bank_q        <= alloc_bank;
				offset_q      <= alloc_off + total_s1[OFF_W-1:0];
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_axis_tdata <= {res_addr, res_bank, res_handle};
			m_axis_tuser <= res_status;
		end
	end

	assign m_axis_tvalid  = out_valid_q;
	assign stat.out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten while held");
	a_handle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_handle_q >= NH_W'(1) && next_handle_q <= NH_W'(MAX_HANDLES))
		else $error("next handle out of range");
	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		OFF_W'(offset_q) <= OFF_W'(BANK_BYTES))
		else $error("bank offset past end of bank");
	a_no_self_write: assert property (@(posedge clk) disable iff (!arst_n)
		tab_we |-> (next_handle_q != '0) && !no_handle)
		else $error("write to self descriptor or past table");
	a_bank_step: assert property (@(posedge clk) disable iff (!arst_n)
		tab_we |=> (bank_q == $past(bank_q)) || (bank_q == $past(bank_q) + BANK_W'(1)))
		else $error("bank moved by more than one");
`endif

endmodule

FILE: rtl/banked_bump_allocator_translate_core.sv
// Top level of the banked bump allocator with handle table and translation.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata 56b, tuser req_type
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata 32b, tuser status
//  cfg       in   cfg_valid / cfg_ready           cfg_data window_base
//
// A request is taken in the idle state, which multiplies count by size and issues
// the descriptor table read; the execute state resolves it and writes the table.
// A finished result sits in the output register while the next beat is taken.
// If the output is still held at resolve time the request waits there.
// Reset is asynchronous; no clearing pass, handle 0 is served from a constant.
// cfg_ready is always high; writes are expected only while idle.
module banked_bump_allocator_translate_core
	import bbat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// elem_count[14:0], elem_size[28:15], handle_in[36:29], elem_index[52:37], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// req_type[0]
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// new_handle[7:0], bank_out[15:8], addr_out[31:16]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic [STATUS_W-1:0]   m_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ADDR_W-1:0]     cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	bbat_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	bbat_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: bench/tb_banked_bump_allocator_translate_core.sv
// Self-checking bench for the banked bump allocator: allocate and translate traffic vs a predictor.
`timescale 1ns / 1ps

module tb_banked_bump_allocator_translate_core;
	import bbat_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP   = 50;

	typedef struct {
		logic               kind;
		logic [COUNT_W-1:0] count;
		logic [SIZE_W-1:0]  size;
		logic [HANDLE_W-1:0] handle;
		logic [INDEX_W-1:0] index;
	} request_t;

	typedef struct {
		logic [HANDLE_W-1:0] handle;
		logic [BANK_W-1:0]   bank;
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] status;
	} outcome_t;

	typedef struct {
		logic [BANK_W-1:0]  bank;
		logic [OFF_W-1:0]   offset;
		logic [COUNT_W-1:0] count;
		logic [SHIFT_W-1:0] shift;
	} region_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [ADDR_W-1:0]     cfg_data = '0;

	// allocator shadow state
	region_t            region_tab [MAX_HANDLES];
	logic [NH_W-1:0]    next_hdl;
	logic [BANK_W-1:0]  cur_bank;
	logic [OFF_W-1:0]   cur_off;
	logic [ADDR_W-1:0]  win_base;

	request_t pending_reqs[$];
	outcome_t awaited_outcomes[$];

	request_t cur_req;
	bit       idle_en = 1'b1;
	int       send_gap = 0;
	int       rdy_gap = 0;
	int       errors = 0;
	int       results_seen = 0;
	int       cycles = 0;
	int       big_issued = 0;
	bit       tail_done = 1'b0;

	banked_bump_allocator_translate_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report(input string msg);
		if (errors < PRINT_CAP)
			$display("MISMATCH %s", msg);
		errors++;
	endtask

	function automatic int ceil_lg(input int v);
		int s;
		s = 0;
		while (s < 31 && (1 << s) < v)
			s++;
		return s;
	endfunction

	task automatic reset_shadow();
		foreach (region_tab[i])
			region_tab[i] = '{bank: '0, offset: '0, count: '0, shift: '0};
		region_tab[0] = '{bank: BANK_W'(TABLE_BANK), offset: '0,
			count: COUNT_W'(BANK_BYTES >> 3), shift: SHIFT_W'(3)};
		next_hdl = NH_W'(1);
		cur_bank = BANK_W'(TABLE_BANK + 1);
		cur_off  = '0;
		win_base = ADDR_W'(40960);
	endtask

	function automatic outcome_t serve_request(input request_t rq);
		outcome_t o;
		logic [TOTAL_W-1:0] total;
		logic [BANK_W-1:0] bnk;
		logic [OFF_W-1:0] off;
		int room;
		region_t rg;
		logic [31:0] wide;
		o = '{handle: '0, bank: '0, addr: '0, status: STAT_OK};
		if (rq.kind == REQ_ALLOC) begin
			total = TOTAL_W'(rq.count) * TOTAL_W'(rq.size);
			bnk = cur_bank;
			off = cur_off;
			room = BANK_BYTES - int'(off);
			if (int'(total) > BANK_BYTES) begin
				o.status = STAT_TOO_LARGE;
			end else if (int'(next_hdl) >= MAX_HANDLES) begin
				o.status = STAT_EXHAUSTED;
			end else if (room < int'(total) && bnk == BANK_LAST) begin
				o.status = STAT_EXHAUSTED;
			end else begin
				if (room < int'(total)) begin
					bnk++;
					off = '0;
				end
				region_tab[next_hdl[TAB_AW-1:0]] = '{bank: bnk, offset: off, count: rq.count,
					shift: SHIFT_W'(ceil_lg(int'(rq.size)))};
				cur_bank = bnk;
				cur_off  = OFF_W'(int'(off) + int'(total));
				o.handle = next_hdl[HANDLE_W-1:0];
				next_hdl++;
			end
		end else begin
			if (int'(rq.handle) >= MAX_HANDLES || rq.index[INDEX_W-1]) begin
				o.status = STAT_BOUNDS;
			end else begin
				rg = region_tab[rq.handle];
				if (rq.index >= INDEX_W'(rg.count)) begin
					o.status = STAT_BOUNDS;
				end else begin
					wide = 32'(win_base) + 32'(rg.offset) + (32'(rq.index) << rg.shift);
					o.bank = rg.bank;
					o.addr = wide[ADDR_W-1:0];
				end
			end
		end
		return o;
	endfunction

	// request driver and result-side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			m_axis_tready <= 1'b0;
			send_gap = 0;
			rdy_gap = 0;
		end else begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (idle_en && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 8);
					s_axis_tvalid <= 1'b0;
				end else begin
					cur_req = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {3'b000, cur_req.index, cur_req.handle, cur_req.size,
						cur_req.count};
					s_axis_tuser <= cur_req.kind;
				end
			end
			if (rdy_gap > 0) begin
				rdy_gap--;
				m_axis_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				rdy_gap = $urandom_range(0, 8);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watches all three channels: tracks window writes, predicts on each request beat, checks each result beat
	always @(posedge clk) begin : monitor
		request_t seen;
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				win_base = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				seen.kind   = s_axis_tuser;
				seen.count  = s_axis_tdata[14:0];
				seen.size   = s_axis_tdata[28:15];
				seen.handle = s_axis_tdata[36:29];
				seen.index  = s_axis_tdata[52:37];
				awaited_outcomes.push_back(serve_request(seen));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.handle = m_axis_tdata[7:0];
				got.bank   = m_axis_tdata[15:8];
				got.addr   = m_axis_tdata[31:16];
				got.status = m_axis_tuser;
				if (awaited_outcomes.size() == 0) begin
					report($sformatf("beat %0d: result with nothing outstanding", results_seen));
				end else begin
					want = awaited_outcomes.pop_front();
					if (got.handle !== want.handle || got.bank !== want.bank ||
							got.addr !== want.addr || got.status !== want.status)
						report($sformatf({"beat %0d: got h%0d bank %0d addr %h st %0d, ",
							"want h%0d bank %0d addr %h st %0d"}, results_seen,
							got.handle, got.bank, got.addr, got.status,
							want.handle, want.bank, want.addr, want.status));
				end
				results_seen++;
			end
		end
	end

	function automatic request_t mk_alloc(input int cnt, input int sz);
		request_t r;
		r.kind   = REQ_ALLOC;
		r.count  = COUNT_W'(cnt);
		r.size   = SIZE_W'(sz);
		r.handle = HANDLE_W'($urandom);
		r.index  = INDEX_W'($urandom);
		return r;
	endfunction

	function automatic request_t mk_xlate(input int hdl, input int idx);
		request_t r;
		r.kind   = REQ_XLATE;
		r.count  = COUNT_W'($urandom);
		r.size   = SIZE_W'($urandom);
		r.handle = HANDLE_W'(hdl);
		r.index  = INDEX_W'(idx);
		return r;
	endfunction

	task automatic wait_slot();
		while (pending_reqs.size() >= 3)
			@(negedge clk);
	endtask

	task automatic queue_req(input request_t r);
		wait_slot();
		pending_reqs.push_back(r);
	endtask

	// Plan: handle 1 fills bank 2, then every sized allocation is over half a bank so each
	// one opens a new bank; 253 of them reach bank 255, the next fails for lack of banks,
	// a zero-size one takes handle 255, and later allocations find the handles used up.
	task automatic push_random();
		int sel;
		int cnt;
		int sz;
		int sh;
		int hdl;
		int idx;
		region_t rg;
		wait_slot();
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			if (sel < 9) begin
				do begin
					cnt = $urandom_range(0, 32767);
					sz  = $urandom_range(0, 16383);
				end while (cnt * sz <= BANK_BYTES);
			end else if (big_issued < 254) begin
				sh  = $urandom_range(0, 13);
				sz  = (sh == 0) ? 1 : $urandom_range((1 << (sh - 1)) + 1, 1 << sh);
				cnt = $urandom_range((4097 + sz - 1) / sz, BANK_BYTES / sz);
				big_issued++;
			end else if (!tail_done) begin
				if ($urandom_range(0, 1) == 0) begin
					cnt = 0;
					sz  = $urandom_range(0, 16383);
				end else begin
					cnt = $urandom_range(0, 32767);
					sz  = 0;
				end
				tail_done = 1'b1;
			end else begin
				cnt = $urandom_range(0, 32767);
				sz  = $urandom_range(0, 16383);
			end
			pending_reqs.push_back(mk_alloc(cnt, sz));
		end else begin
			// only handles the shadow already knows about, so no unwritten entry is read
			hdl = (sel < 52) ? int'(next_hdl) - 1 : $urandom_range(0, int'(next_hdl) - 1);
			rg = region_tab[hdl];
			sel = $urandom_range(0, 9);
			if (rg.count != 0 && sel == 0)
				idx = int'(rg.count) - 1;
			else if (rg.count != 0 && sel < 7)
				idx = $urandom_range(0, int'(rg.count) - 1);
			else if (sel == 7)
				idx = int'(rg.count);
			else if (sel == 8)
				idx = $urandom_range(int'(rg.count), 32767);
			else
				idx = $urandom_range(32768, 65535);
			pending_reqs.push_back(mk_xlate(hdl, idx));
		end
	endtask

	task automatic run_random(input int n);
		repeat (n)
			push_random();
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || s_axis_tvalid || awaited_outcomes.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_window(input logic [ADDR_W-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		reset_shadow();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: the table's own entry, index edges, oversize, first allocation
		queue_req(mk_xlate(0, 0));
		queue_req(mk_xlate(0, 1023));
		queue_req(mk_xlate(0, 1024));
		queue_req(mk_xlate(0, 16'hFFFF));
		queue_req(mk_xlate(0, 16'h8000));
		queue_req(mk_xlate(0, 16'h7FFF));
		queue_req(mk_alloc(32767, 16383));
		queue_req(mk_alloc(8193, 1));
		queue_req(mk_alloc(1, 8193));
		queue_req(mk_alloc(1, BANK_BYTES));
		queue_req(mk_xlate(1, 0));
		queue_req(mk_xlate(1, 1));
		queue_req(mk_xlate(1, 16'hFFFF));
		queue_req(mk_xlate(0, 512));
		drain();

		write_window('0);
		run_random(200);
		drain();

		write_window('1);
		run_random(200);
		drain();

		write_window(ADDR_W'($urandom_range(0, 65535)));
		run_random(200);
		drain();

		// closing stretch with both sides always ready
		idle_en = 1'b0;
		write_window(ADDR_W'($urandom_range(0, 65535)));
		run_random(200);
		while (!tail_done)
			push_random();
		run_random(80);
		drain();
		repeat (10) @(negedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: banked_bump_allocator_translate_core.f
rtl/bbat_pkg.sv
rtl/bbat_ram.sv
rtl/bbat_ctrl.sv
rtl/bbat_dp.sv
rtl/banked_bump_allocator_translate_core.sv
bench/tb_banked_bump_allocator_translate_core.sv
